// ===== src/assert_macros.svh =====
// Assertion macros shared by the modular power RTL.
// Expects clk and rst_n (active low) in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define AST_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/mpow_pkg.sv =====
// Types and constants for the modular power block.
// No dependencies.
package mpow_pkg;

    localparam int unsigned OP_W = 30;
    localparam int unsigned EXP_W = 32;

    localparam logic [OP_W-1:0] MODULUS = 30'd1000000007;
    // floor(2^60 / MODULUS), Barrett reciprocal
    localparam logic [30:0] BARRETT_MU = 31'd1152921496;

    typedef enum logic [2:0] {
        MM_IDLE,
        MM_MUL,
        MM_EST,
        MM_QM,
        MM_SUB,
        MM_FIX
    } mm_state_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_CHECK,
        T_MULW,
        T_SQRW
    } top_state_t;

    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] a;
        logic [OP_W-1:0] b;
    } mm_req_t;

    typedef struct packed {
        logic            done;
        logic [OP_W-1:0] result;
    } mm_rsp_t;

endpackage

// ===== src/mpow_modmul.sv =====
// Multicycle modular multiplier (Barrett reduction) on one shared 31x31 multiplier.
// Depends on mpow_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mpow_modmul
    import mpow_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  mm_req_t req,
    output mm_rsp_t rsp
);

    mm_state_t       state_reg, state_next;
    logic [OP_W-1:0] opa_reg, opa_next;
    logic [OP_W-1:0] opb_reg, opb_next;
    logic [59:0]     p_reg, p_next;
    logic [61:0]     q_reg, q_next;
    logic [31:0]     r_reg, r_next;

    logic [30:0]     mul_x, mul_y;
    logic [61:0]     mul_out;
    logic            ready;

    assign mul_out = mul_x * mul_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        p_reg   <= p_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
    end

    always_comb
    begin
        state_next = state_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        mul_x      = '0;
        mul_y      = '0;
        rsp.done   = 1'b0;
        rsp.result = r_reg[OP_W-1:0];
        ready      = 1'b0;

        case (state_reg)
            MM_IDLE:
            begin
                ready = 1'b1;
            end
            MM_MUL:
            begin
                mul_x      = {1'b0, opa_reg};
                mul_y      = {1'b0, opb_reg};
                p_next     = mul_out[59:0];
                state_next = MM_EST;
            end
            MM_EST:
            begin
                mul_x      = p_reg[59:29];
                mul_y      = BARRETT_MU;
                q_next     = mul_out;
                state_next = MM_QM;
            end
            MM_QM:
            begin
                mul_x      = q_reg[61:31];
                mul_y      = {1'b0, MODULUS};
                q_next     = mul_out;
                state_next = MM_SUB;
            end
            MM_SUB:
            begin
                r_next     = p_reg[31:0] - q_reg[31:0];
                state_next = MM_FIX;
            end
            MM_FIX:
            begin
                if (r_reg >= {2'b00, MODULUS})
                begin
                    r_next = r_reg - {2'b00, MODULUS};
                end
                else
                begin
                    rsp.done   = 1'b1;
                    ready      = 1'b1;
                    state_next = MM_IDLE;
                end
            end
            default:
            begin
                state_next = MM_IDLE;
            end
        endcase

        if (ready && req.start)
        begin
            opa_next   = req.a;
            opb_next   = req.b;
            state_next = MM_MUL;
        end
    end

    `AST_IMPL(mm_result_reduced, rsp.done, rsp.result < MODULUS,
        "modmul result not reduced")
    `AST_IMPL(mm_start_when_ready, req.start, state_reg == MM_IDLE || rsp.done,
        "modmul started while busy")
    `AST_NEXT(mm_sub_then_fix, state_reg == MM_SUB, state_reg == MM_FIX,
        "modmul skipped correction")

endmodule

// ===== src/modular_power_top.sv =====
// Modular exponentiation base^exponent mod 1000000007, right-to-left square-and-multiply.
// Depends on mpow_pkg, mpow_modmul and assert_macros.svh.
//
// One item is in flight at a time; in_stall stays high from the transfer until
// the result is loaded into the output register, and a new item may be taken
// while that result still waits. Each modular product runs on the shared 31x31
// multiplier in turn: product, Barrett estimate, quotient times modulus,
// subtract, up to two corrections. For an exponent whose top set bit is bit n,
// with c bits set, an item takes n squarings and c multiplies.
`include "assert_macros.svh"

module modular_power_top
    import mpow_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     base,
    input  logic [EXP_W-1:0]    exponent,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [OP_W-1:0]     power
);

    top_state_t       state_reg, state_next;
    logic [OP_W-1:0]  acc_reg, acc_next;
    logic [OP_W-1:0]  sq_reg, sq_next;
    logic [EXP_W-1:0] e_reg, e_next;
    logic [OP_W-1:0]  power_reg, power_next;
    logic             out_valid_reg, out_valid_next;

    mm_req_t mm_req;
    mm_rsp_t mm_rsp;

    mpow_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

    assign in_stall  = (state_reg != T_IDLE);
    assign out_valid = out_valid_reg;
    assign power     = power_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        sq_reg    <= sq_next;
        e_reg     <= e_next;
        power_reg <= power_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        e_next         = e_reg;
        power_next     = power_reg;
        out_valid_next = out_valid_reg;
        mm_req.start   = 1'b0;
        mm_req.a       = sq_reg;
        mm_req.b       = sq_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            T_IDLE:
            begin
                if (in_valid)
                begin
                    sq_next    = (base >= MODULUS) ? base - MODULUS : base;
                    e_next     = exponent;
                    acc_next   = OP_W'(1);
                    state_next = T_CHECK;
                end
            end
            T_CHECK:
            begin
                if (e_reg == '0)
                begin
                    // wait for the output register to free up
                    if (!out_valid_reg || !out_stall)
                    begin
                        power_next     = acc_reg;
                        out_valid_next = 1'b1;
                        state_next     = T_IDLE;
                    end
                end
                else if (e_reg[0])
                begin
                    mm_req.start = 1'b1;
                    mm_req.a     = acc_reg;
                    state_next   = T_MULW;
                end
                else
                begin
                    mm_req.start = 1'b1;
                    state_next   = T_SQRW;
                end
            end
            T_MULW:
            begin
                if (mm_rsp.done)
                begin
                    acc_next = mm_rsp.result;
                    if (e_reg[EXP_W-1:1] == '0)
                    begin
                        // last set bit: the final squaring is not needed
                        e_next     = '0;
                        state_next = T_CHECK;
                    end
                    else
                    begin
                        mm_req.start = 1'b1;
                        state_next   = T_SQRW;
                    end
                end
            end
            T_SQRW:
            begin
                if (mm_rsp.done)
                begin
                    sq_next    = mm_rsp.result;
                    e_next     = e_reg >> 1;
                    state_next = T_CHECK;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    `AST_IMPL(top_power_reduced, out_valid, power < MODULUS,
        "power not reduced")
    `AST_NEXT(top_exp_shift, state_reg == T_SQRW && mm_rsp.done,
        e_reg == ($past(e_reg) >> 1), "exponent not shifted after square")
    `AST_IMPL(top_square_reduced, state_reg != T_IDLE, sq_reg < MODULUS,
        "running square not reduced")

endmodule
